/* src/delta_sample_channel_assert.svh */
// Assertion macros used by the delta sample channel core (dsc_core).
`ifndef DELTA_SAMPLE_CHANNEL_ASSERT_SVH
`define DELTA_SAMPLE_CHANNEL_ASSERT_SVH

`ifndef ASSERT_OFF
`define DSC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define DSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DSC_ASSERT(lbl, clk, rst_n, prop)
`define DSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* src/dsc_pkg.sv */
// Shared types, opcodes and the rate table of the delta sample channel.
`timescale 1ns / 1ps

package dsc_pkg;

  localparam int LEN_W = 12;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_CTRL   = 3'd1;
  localparam logic [2:0] OP_LEVEL  = 3'd2;
  localparam logic [2:0] OP_ADDR   = 3'd3;
  localparam logic [2:0] OP_LENGTH = 3'd4;
  localparam logic [2:0] OP_ENABLE = 3'd5;
  localparam logic [2:0] OP_STATUS = 3'd6;
  localparam logic [2:0] OP_FETCH  = 3'd7;

  localparam logic [15:0] BASE_ADDR = 16'h8000;
  localparam logic [6:0]  LEVEL_TOP = 7'd125;

  typedef struct packed {
    logic [6:0]  level;
    logic        fetch_request;
    logic [15:0] fetch_address;
    logic        irq;
    logic [7:0]  status_data;
  } dsc_result_t;

  function automatic logic [8:0] rate_lookup(input logic [3:0] sel);
    logic [8:0] p;
    case (sel)
      4'd0:    p = 9'd428;
      4'd1:    p = 9'd380;
      4'd2:    p = 9'd340;
      4'd3:    p = 9'd320;
      4'd4:    p = 9'd286;
      4'd5:    p = 9'd254;
      4'd6:    p = 9'd226;
      4'd7:    p = 9'd214;
      4'd8:    p = 9'd190;
      4'd9:    p = 9'd160;
      4'd10:   p = 9'd142;
      4'd11:   p = 9'd128;
      4'd12:   p = 9'd106;
      4'd13:   p = 9'd84;
      4'd14:   p = 9'd72;
      default: p = 9'd54;
    endcase
    return p;
  endfunction

endpackage

/* src/delta_sample_channel.sv */
// Delta sample channel: one-bit DPCM sample player, top level.
// Usage: each input beat carries in_opcode and in_data: a timer tick, a
// register write (ctrl, level, address, length, enable), a status read or a
// fetched sample byte. Every input beat yields exactly one result beat with
// the current level, a fetch request and address, the irq line and status.
// A fetch request is answered later by sending the byte as a fetch beat.
// An accepted beat is held in the input register; when it advances, it is applied
// to the channel state and loaded into the result register on the same edge, and
// then appears on out_valid. Throughput: one beat per cycle while out_stall does
// not hold the result, set by the combinational state update between the registers.
// Reset (rst_n low, synchronous) empties both registers and restores the
// channel state: start address 0x8000, length 1, rate 428, level 0.
// When the receiver holds out_stall, the result stays on the port; one more
// beat can still enter the input register, after which in_stall rises until
// the result is taken.
`timescale 1ns / 1ps

module delta_sample_channel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_level,
  output logic        out_fetch_request,
  output logic [15:0] out_fetch_address,
  output logic        out_irq,
  output logic [7:0]  out_status_data
);

  logic                 in_v_r, in_v_nxt;
  logic [2:0]           op_r;
  logic [7:0]           data_r;
  logic                 advance;
  logic                 in_take;
  dsc_pkg::dsc_result_t res;
  dsc_pkg::dsc_result_t out_res;

  assign advance  = in_v_r && (!out_valid || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_opcode;
      data_r <= in_data;
    end
  end

  dsc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .opcode (op_r),
    .data   (data_r),
    .res    (res)
  );

  dsc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_level         = out_res.level;
  assign out_fetch_request = out_res.fetch_request;
  assign out_fetch_address = out_res.fetch_address;
  assign out_irq           = out_res.irq;
  assign out_status_data   = out_res.status_data;

endmodule

/* src/dsc_core.sv */
// Channel state and the per-beat update of the delta sample channel.
`timescale 1ns / 1ps
`include "delta_sample_channel_assert.svh"

module dsc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [2:0]          opcode,
  input  logic [7:0]          data,
  output dsc_pkg::dsc_result_t res
);

  logic [15:0]              start_r, start_nxt;
  logic [dsc_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [15:0]              addr_r, addr_nxt;
  logic [dsc_pkg::LEN_W-1:0] remain_r, remain_nxt;
  logic [7:0]               buf_r, buf_nxt;
  logic                     buf_full_r, buf_full_nxt;
  logic [7:0]               shift_r, shift_nxt;
  logic [3:0]               bits_r, bits_nxt;
  logic                     silent_r, silent_nxt;
  logic [6:0]               level_r, level_nxt;
  logic                     irq_flag_r, irq_flag_nxt;
  logic                     irq_en_r, irq_en_nxt;
  logic                     loop_r, loop_nxt;
  logic [8:0]               rate_r, rate_nxt;
  logic [8:0]               cd_r, cd_nxt;

  logic [8:0]               cd_dec;
  logic [3:0]               bits_dec;
  logic [dsc_pkg::LEN_W-1:0] remain_dec;
  logic [15:0]              addr_inc;
  logic                     take_byte;
  logic                     req;
  logic [7:0]               status;

  assign cd_dec     = (cd_r != 9'd0) ? cd_r - 9'd1 : 9'd0;
  assign bits_dec   = bits_r - 4'd1;
  assign remain_dec = remain_r - dsc_pkg::LEN_W'(1);
  assign addr_inc   = (addr_r == 16'hFFFF) ? dsc_pkg::BASE_ADDR : addr_r + 16'd1;
  assign take_byte  = (opcode == dsc_pkg::OP_FETCH) && !buf_full_r && (remain_r != '0);

  always_comb begin
    start_nxt    = start_r;
    len_nxt      = len_r;
    addr_nxt     = addr_r;
    remain_nxt   = remain_r;
    buf_nxt      = buf_r;
    buf_full_nxt = buf_full_r;
    shift_nxt    = shift_r;
    bits_nxt     = bits_r;
    silent_nxt   = silent_r;
    level_nxt    = level_r;
    irq_flag_nxt = irq_flag_r;
    irq_en_nxt   = irq_en_r;
    loop_nxt     = loop_r;
    rate_nxt     = rate_r;
    cd_nxt       = cd_r;
    req          = 1'b0;
    status       = 8'd0;
    unique case (opcode)
      dsc_pkg::OP_TICK: begin
        cd_nxt = cd_dec;
        if (cd_dec == 9'd0) begin
          cd_nxt = rate_r;
          if (!silent_r) begin
            if (shift_r[0]) begin
              if (level_r <= dsc_pkg::LEVEL_TOP) level_nxt = level_r + 7'd2;
            end else begin
              if (level_r >= 7'd2) level_nxt = level_r - 7'd2;
            end
          end
          shift_nxt = {1'b0, shift_r[7:1]};
          bits_nxt  = bits_dec;
          if (bits_dec == 4'd0) begin
            bits_nxt     = 4'd8;
            silent_nxt   = !buf_full_r;
            shift_nxt    = buf_full_r ? buf_r : 8'd0;
            buf_full_nxt = 1'b0;
          end
          req = (remain_r != '0) && !buf_full_nxt;
        end
      end
      dsc_pkg::OP_CTRL: begin
        irq_en_nxt = data[7];
        if (!data[7]) irq_flag_nxt = 1'b0;
        loop_nxt = data[6];
        rate_nxt = dsc_pkg::rate_lookup(data[3:0]);
      end
      dsc_pkg::OP_LEVEL: begin
        level_nxt = data[6:0];
      end
      dsc_pkg::OP_ADDR: begin
        start_nxt = {2'b10, data, 6'd0};
      end
      dsc_pkg::OP_LENGTH: begin
        len_nxt = dsc_pkg::LEN_W'({data, 4'h1});
      end
      dsc_pkg::OP_ENABLE: begin
        if (data[4]) begin
          if (remain_r == '0) begin
            addr_nxt   = start_r;
            remain_nxt = len_r;
            cd_nxt     = 9'd1;
          end
        end else begin
          remain_nxt = '0;
        end
        irq_flag_nxt = 1'b0;
      end
      dsc_pkg::OP_STATUS: begin
        status = {irq_flag_r, 2'b00, remain_r != '0, 4'h0};
      end
      dsc_pkg::OP_FETCH: begin
        if (take_byte) begin
          buf_nxt      = data;
          buf_full_nxt = 1'b1;
          addr_nxt     = addr_inc;
          remain_nxt   = remain_dec;
          if (remain_dec == '0) begin
            if (loop_r) begin
              addr_nxt   = start_r;
              remain_nxt = len_r;
            end else if (irq_en_r) begin
              irq_flag_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
        status = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= dsc_pkg::BASE_ADDR;
      len_r      <= dsc_pkg::LEN_W'(1);
      addr_r     <= 16'd0;
      remain_r   <= '0;
      buf_r      <= 8'd0;
      buf_full_r <= 1'b0;
      shift_r    <= 8'd0;
      bits_r     <= 4'd8;
      silent_r   <= 1'b0;
      level_r    <= 7'd0;
      irq_flag_r <= 1'b0;
      irq_en_r   <= 1'b0;
      loop_r     <= 1'b0;
      rate_r     <= dsc_pkg::rate_lookup(4'd0);
      cd_r       <= 9'd0;
    end else if (step) begin
      start_r    <= start_nxt;
      len_r      <= len_nxt;
      addr_r     <= addr_nxt;
      remain_r   <= remain_nxt;
      buf_r      <= buf_nxt;
      buf_full_r <= buf_full_nxt;
      shift_r    <= shift_nxt;
      bits_r     <= bits_nxt;
      silent_r   <= silent_nxt;
      level_r    <= level_nxt;
      irq_flag_r <= irq_flag_nxt;
      irq_en_r   <= irq_en_nxt;
      loop_r     <= loop_nxt;
      rate_r     <= rate_nxt;
      cd_r       <= cd_nxt;
    end
  end

  assign res.level         = level_nxt;
  assign res.fetch_request = req;
  assign res.fetch_address = req ? addr_r : 16'd0;
  assign res.irq           = irq_flag_nxt;
  assign res.status_data   = status;

  `DSC_ASSERT(a_bits_range, clk, rst_n, bits_r != 4'd0 && bits_r <= 4'd8)
  `DSC_ASSERT(a_addr_high, clk, rst_n, addr_r == 16'd0 || addr_r[15])
  `DSC_ASSERT_NEXT(a_fetch_fills, clk, rst_n, step && take_byte, buf_full_r)
  `DSC_ASSERT_NEXT(a_req_needs_bytes, clk, rst_n, step && req, remain_r != '0 && !buf_full_r)

endmodule

/* src/dsc_out_reg.sv */
// Result register of the delta sample channel.
`timescale 1ns / 1ps

module dsc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  dsc_pkg::dsc_result_t res,
  input  logic                out_stall,
  output logic                out_valid,
  output dsc_pkg::dsc_result_t out_res
);

  logic                 valid_r, valid_nxt;
  dsc_pkg::dsc_result_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
